@@ design/dmpd_pkg.sv @@
// Package for the dual-motor proportional drive controller.
// Field widths, reset values, register indices, status codes and shared types.
// No dependencies.
`default_nettype none

package dmpd_pkg;

    localparam int FRACTION_BITS_DEF = 8;

    localparam int GAIN_W    = 16;
    localparam int LIMIT_W   = 12;
    localparam int TIMEOUT_W = 16;
    localparam int CMP_W     = 12;
    localparam int TARGET_W  = 16;
    localparam int ELAPSED_W = 16;
    localparam int STATUS_W  = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [GAIN_W-1:0]    GAIN_RST    = 16'd9830;
    localparam logic [LIMIT_W-1:0]   LIMIT_RST   = 12'd2450;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd16000;
    localparam logic [CMP_W-1:0]     IDLE_RST    = 12'd24;
    localparam logic [CMP_W-1:0]     CMP_RST     = 12'd24;

    localparam logic [STATUS_W-1:0] ST_RUNNING  = 2'b00;
    localparam logic [STATUS_W-1:0] ST_OVERTEMP = 2'b01;
    localparam logic [STATUS_W-1:0] ST_FAULT    = 2'b10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN    = 2'd0,
        REG_LIMIT   = 2'd1,
        REG_TIMEOUT = 2'd2,
        REG_IDLE    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0]    gain;
        logic [LIMIT_W-1:0]   saturation_limit;
        logic [TIMEOUT_W-1:0] timeout_count;
        logic [CMP_W-1:0]     idle_compare;
    } t_cfg;

    typedef struct packed {
        logic                        temp_ok;
        logic                        fault_ok;
        logic signed [TARGET_W-1:0]  target_one;
        logic signed [TARGET_W-1:0]  target_two;
        logic [ELAPSED_W-1:0]        elapsed_one;
        logic [ELAPSED_W-1:0]        elapsed_two;
    } t_in_item;

endpackage

`default_nettype wire

@@ design/dmpd_in_if.sv @@
// Input channel of the drive controller: one control tick per item.
// Depends on dmpd_pkg.
`default_nettype none

interface dmpd_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 temp_ok;
    logic                                 fault_ok;
    logic signed [dmpd_pkg::TARGET_W-1:0] target_one;
    logic signed [dmpd_pkg::TARGET_W-1:0] target_two;
    logic [dmpd_pkg::ELAPSED_W-1:0]       elapsed_one;
    logic [dmpd_pkg::ELAPSED_W-1:0]       elapsed_two;

    modport source (
        output valid, temp_ok, fault_ok, target_one, target_two, elapsed_one, elapsed_two,
        input  ready
    );
    modport sink (
        input  valid, temp_ok, fault_ok, target_one, target_two, elapsed_one, elapsed_two,
        output ready
    );
endinterface

`default_nettype wire

@@ design/dmpd_out_if.sv @@
// Result channel of the drive controller: four leg compares and a status code.
// Depends on dmpd_pkg.
`default_nettype none

interface dmpd_out_if;
    logic                             valid;
    logic                             ready;
    logic [dmpd_pkg::CMP_W-1:0]       motor_one_leg_a;
    logic [dmpd_pkg::CMP_W-1:0]       motor_one_leg_b;
    logic [dmpd_pkg::CMP_W-1:0]       motor_two_leg_a;
    logic [dmpd_pkg::CMP_W-1:0]       motor_two_leg_b;
    logic [dmpd_pkg::STATUS_W-1:0]    drive_status;

    modport source (
        output valid, motor_one_leg_a, motor_one_leg_b, motor_two_leg_a, motor_two_leg_b,
        output drive_status,
        input  ready
    );
    modport sink (
        input  valid, motor_one_leg_a, motor_one_leg_b, motor_two_leg_a, motor_two_leg_b,
        input  drive_status,
        output ready
    );
endinterface

`default_nettype wire

@@ design/dmpd_cfg_regs.sv @@
// Configuration register file: gain, saturation limit, timeout, idle compare.
// Depends on dmpd_pkg.
`default_nettype none

module dmpd_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_we,
    input  logic [dmpd_pkg::CFG_IDX_W-1:0]      i_idx,
    input  logic [dmpd_pkg::CFG_DATA_W-1:0]     i_data,
    output dmpd_pkg::t_cfg                      o_cfg
);

    dmpd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain             <= dmpd_pkg::GAIN_RST;
            r_cfg.saturation_limit <= dmpd_pkg::LIMIT_RST;
            r_cfg.timeout_count    <= dmpd_pkg::TIMEOUT_RST;
            r_cfg.idle_compare     <= dmpd_pkg::IDLE_RST;
        end else if (i_we) begin
            case (dmpd_pkg::t_cfg_idx'(i_idx))
                dmpd_pkg::REG_GAIN: begin
                    r_cfg.gain <= i_data[dmpd_pkg::GAIN_W-1:0];
                end
                dmpd_pkg::REG_LIMIT: begin
                    r_cfg.saturation_limit <= i_data[dmpd_pkg::LIMIT_W-1:0];
                end
                dmpd_pkg::REG_TIMEOUT: begin
                    r_cfg.timeout_count <= i_data[dmpd_pkg::TIMEOUT_W-1:0];
                end
                dmpd_pkg::REG_IDLE: begin
                    r_cfg.idle_compare <= i_data[dmpd_pkg::CMP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ design/dmpd_motor.sv @@
// One motor channel: fixed-point level register, proportional step with clamp,
// and sign-magnitude mapping of the new level onto two leg compares.
// Depends on dmpd_pkg.
`default_nettype none

module dmpd_motor #(
    parameter int FRACTION_BITS = dmpd_pkg::FRACTION_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic signed [dmpd_pkg::TARGET_W-1:0] i_target,
    input  logic [dmpd_pkg::ELAPSED_W-1:0]       i_elapsed,
    input  dmpd_pkg::t_cfg                       i_cfg,
    output logic [dmpd_pkg::CMP_W-1:0]           o_leg_a,
    output logic [dmpd_pkg::CMP_W-1:0]           o_leg_b
);

    localparam int LW = dmpd_pkg::CMP_W + 1 + FRACTION_BITS;
    localparam int TW = dmpd_pkg::TARGET_W + FRACTION_BITS;
    localparam int EW = TW + 1;
    localparam int GW = dmpd_pkg::GAIN_W + 1;
    localparam int PW = EW + GW;
    localparam int SW = PW - dmpd_pkg::GAIN_W;
    localparam int NW = SW + 1;

    logic signed [LW-1:0]                 r_level;
    logic signed [LW-1:0]                 n_level;
    logic signed [dmpd_pkg::TARGET_W-1:0] w_tgt;
    logic signed [TW-1:0]                 w_tgt_q;
    logic signed [EW-1:0]                 w_err;
    logic signed [GW-1:0]                 w_gain;
    logic signed [PW-1:0]                 w_prod;
    logic signed [SW-1:0]                 w_step;
    logic signed [NW-1:0]                 w_sum;
    logic signed [NW-1:0]                 w_lim;
    logic [LW-1:0]                        w_abs;
    logic [dmpd_pkg::CMP_W-1:0]           w_mag;
    logic                                 w_neg;

    assign w_tgt   = (i_elapsed == i_cfg.timeout_count) ? '0 : i_target;
    assign w_tgt_q = {w_tgt, {FRACTION_BITS{1'b0}}};
    assign w_err   = EW'(w_tgt_q) - EW'(r_level);
    assign w_gain  = {1'b0, i_cfg.gain};
    assign w_prod  = w_err * w_gain;
    // floor of the Q0.16 product
    assign w_step  = w_prod[PW-1:dmpd_pkg::GAIN_W];
    assign w_sum   = NW'(r_level) + NW'(w_step);
    assign w_lim   = NW'({i_cfg.saturation_limit, {FRACTION_BITS{1'b0}}});

    always_comb begin
        if (w_sum > w_lim) begin
            n_level = LW'(w_lim);
        end else if (w_sum < -w_lim) begin
            n_level = LW'(-w_lim);
        end else begin
            n_level = LW'(w_sum);
        end
    end

    // truncation toward zero; a level in (-1,0) drives the non-negative pattern
    assign w_abs = n_level[LW-1] ? LW'(-n_level) : LW'(n_level);
    assign w_mag = w_abs[FRACTION_BITS +: dmpd_pkg::CMP_W];
    assign w_neg = n_level[LW-1] && (w_mag != '0);

    assign o_leg_a = w_neg ? w_mag : i_cfg.idle_compare;
    assign o_leg_b = w_neg ? i_cfg.idle_compare : w_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_en) begin
            r_level <= n_level;
        end
    end

endmodule

`default_nettype wire

@@ design/dual_motor_p_drive_controller_unit.sv @@
// Dual-motor proportional drive controller, top level.
// An accepted item passes the input register, then the level update and
// compare mapping into the result register.
// Throughput: one item per cycle while the result side takes one per cycle.
// Synchronous active-low reset clears levels to zero, compares to 24,
// configuration to its defaults and both stages to empty.
`default_nettype none

module dual_motor_p_drive_controller_unit #(
    parameter int FRACTION_BITS = dmpd_pkg::FRACTION_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    dmpd_in_if.sink                         i_in,
    dmpd_out_if.source                      o_res,
    input  logic                            i_cfg_we,
    input  logic [dmpd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dmpd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    dmpd_pkg::t_cfg                w_cfg;
    dmpd_pkg::t_in_item            r_in;
    logic                          r_in_valid;
    logic                          r_out_valid;
    logic [dmpd_pkg::CMP_W-1:0]    r_cmp [4];
    logic [dmpd_pkg::STATUS_W-1:0] r_status;
    logic [dmpd_pkg::STATUS_W-1:0] w_status;
    logic                          w_running;
    logic                          w_adv;
    logic                          w_take;
    logic [dmpd_pkg::CMP_W-1:0]    w_leg [4];

    dmpd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    assign w_adv       = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_in.ready  = !r_in_valid || w_adv;
    assign w_take      = i_in.valid && i_in.ready;

    assign w_status  = (r_in.temp_ok  ? dmpd_pkg::ST_RUNNING : dmpd_pkg::ST_OVERTEMP)
                     | (r_in.fault_ok ? dmpd_pkg::ST_RUNNING : dmpd_pkg::ST_FAULT);
    assign w_running = (w_status == dmpd_pkg::ST_RUNNING);

    dmpd_motor #(.FRACTION_BITS(FRACTION_BITS)) u_motor_one (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_adv && w_running),
        .i_target  (r_in.target_one),
        .i_elapsed (r_in.elapsed_one),
        .i_cfg     (w_cfg),
        .o_leg_a   (w_leg[0]),
        .o_leg_b   (w_leg[1])
    );

    dmpd_motor #(.FRACTION_BITS(FRACTION_BITS)) u_motor_two (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_adv && w_running),
        .i_target  (r_in.target_two),
        .i_elapsed (r_in.elapsed_two),
        .i_cfg     (w_cfg),
        .o_leg_a   (w_leg[2]),
        .o_leg_b   (w_leg[3])
    );

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in.temp_ok     <= i_in.temp_ok;
            r_in.fault_ok    <= i_in.fault_ok;
            r_in.target_one  <= i_in.target_one;
            r_in.target_two  <= i_in.target_two;
            r_in.elapsed_one <= i_in.elapsed_one;
            r_in.elapsed_two <= i_in.elapsed_two;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // compare registers double as the result payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp[0] <= dmpd_pkg::CMP_RST;
            r_cmp[1] <= dmpd_pkg::CMP_RST;
            r_cmp[2] <= dmpd_pkg::CMP_RST;
            r_cmp[3] <= dmpd_pkg::CMP_RST;
            r_status <= dmpd_pkg::ST_RUNNING;
        end else if (w_adv) begin
            r_status <= w_status;
            if (w_running) begin
                r_cmp[0] <= w_leg[0];
                r_cmp[1] <= w_leg[1];
                r_cmp[2] <= w_leg[2];
                r_cmp[3] <= w_leg[3];
            end else begin
                r_cmp[0] <= '0;
                r_cmp[1] <= '0;
            end
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.motor_one_leg_a = r_cmp[0];
    assign o_res.motor_one_leg_b = r_cmp[1];
    assign o_res.motor_two_leg_a = r_cmp[2];
    assign o_res.motor_two_leg_b = r_cmp[3];
    assign o_res.drive_status    = r_status;

endmodule

`default_nettype wire

@@ tb/dmpd_checker.sv @@
// Checker for the dual-motor drive controller: watches the tick, result and
// register-write ports, predicts each result and compares it field by field.
// Depends on dmpd_pkg, dmpd_in_if and dmpd_out_if.
`timescale 1ns / 1ps

module dmpd_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    dmpd_in_if                              in_ch,
    dmpd_out_if                             res_ch,
    input  logic                            i_cfg_we,
    input  logic [dmpd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dmpd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);
    import dmpd_pkg::*;

    localparam int FB      = FRACTION_BITS_DEF;
    localparam int LEVEL_W = 13 + FB;

    typedef struct packed {
        logic [CMP_W-1:0]    one_a;
        logic [CMP_W-1:0]    one_b;
        logic [CMP_W-1:0]    two_a;
        logic [CMP_W-1:0]    two_b;
        logic [STATUS_W-1:0] status;
    } t_drive_out;

    logic [GAIN_W-1:0]           gain_q;
    logic [LIMIT_W-1:0]          limit_q;
    logic [TIMEOUT_W-1:0]        timeout_q;
    logic [CMP_W-1:0]            idle_q;
    logic signed [LEVEL_W-1:0]   level_one_q;
    logic signed [LEVEL_W-1:0]   level_two_q;
    logic [CMP_W-1:0]            cmp_q [4];
    t_drive_out                  drive_q [$];
    int                          fails = 0;

    function automatic logic signed [LEVEL_W-1:0] move_level(
        input logic signed [LEVEL_W-1:0] lvl,
        input longint                    tgt
    );
        longint lim;
        longint err;
        longint nxt;
        lim = longint'(limit_q) <<< FB;
        err = (tgt <<< FB) - longint'(lvl);
        // arithmetic shift floors the Q0.16 product
        nxt = longint'(lvl) + ((err * longint'(gain_q)) >>> 16);
        if (nxt > lim)
            nxt = lim;
        if (nxt < -lim)
            nxt = -lim;
        return nxt[LEVEL_W-1:0];
    endfunction

    function automatic void map_legs(
        input  logic signed [LEVEL_W-1:0] lvl,
        output logic [CMP_W-1:0]          leg_a,
        output logic [CMP_W-1:0]          leg_b
    );
        longint v;
        longint mag;
        v = longint'(lvl);
        if (v > -(longint'(1) <<< FB)) begin
            mag   = (v > 0) ? (v >>> FB) : 0;
            leg_a = idle_q;
            leg_b = mag[CMP_W-1:0];
        end else begin
            mag   = (-v) >>> FB;
            leg_a = mag[CMP_W-1:0];
            leg_b = idle_q;
        end
    endfunction

    function automatic t_drive_out predict_drive(input t_in_item tick);
        t_drive_out res;
        longint     t1;
        longint     t2;
        res.status = ST_RUNNING;
        if (!tick.temp_ok)
            res.status = res.status | ST_OVERTEMP;
        if (!tick.fault_ok)
            res.status = res.status | ST_FAULT;
        if (res.status == ST_RUNNING) begin
            t1 = (tick.elapsed_one == timeout_q) ? 0 : longint'(tick.target_one);
            t2 = (tick.elapsed_two == timeout_q) ? 0 : longint'(tick.target_two);
            level_one_q = move_level(level_one_q, t1);
            level_two_q = move_level(level_two_q, t2);
            map_legs(level_one_q, cmp_q[0], cmp_q[1]);
            map_legs(level_two_q, cmp_q[2], cmp_q[3]);
        end else begin
            // motor one off, motor two holds
            cmp_q[0] = '0;
            cmp_q[1] = '0;
        end
        res.one_a = cmp_q[0];
        res.one_b = cmp_q[1];
        res.two_a = cmp_q[2];
        res.two_b = cmp_q[3];
        return res;
    endfunction

    task automatic check_field(input string name, input logic [CMP_W-1:0] want,
                               input logic [CMP_W-1:0] got);
        if (got !== want) begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_drive_out want;
        t_drive_out got;
        t_in_item   tick;
        if (!i_rst_n) begin
            gain_q      = GAIN_RST;
            limit_q     = LIMIT_RST;
            timeout_q   = TIMEOUT_RST;
            idle_q      = IDLE_RST;
            level_one_q = '0;
            level_two_q = '0;
            for (int i = 0; i < 4; i++)
                cmp_q[i] = CMP_RST;
            drive_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    REG_GAIN:    gain_q    = i_cfg_data[GAIN_W-1:0];
                    REG_LIMIT:   limit_q   = i_cfg_data[LIMIT_W-1:0];
                    REG_TIMEOUT: timeout_q = i_cfg_data[TIMEOUT_W-1:0];
                    REG_IDLE:    idle_q    = i_cfg_data[CMP_W-1:0];
                    default: ;
                endcase
            end
            if (res_ch.valid && res_ch.ready) begin
                got.one_a  = res_ch.motor_one_leg_a;
                got.one_b  = res_ch.motor_one_leg_b;
                got.two_a  = res_ch.motor_two_leg_a;
                got.two_b  = res_ch.motor_two_leg_b;
                got.status = res_ch.drive_status;
                if (drive_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result %0d %0d %0d %0d status %0d", $time,
                             got.one_a, got.one_b, got.two_a, got.two_b, got.status);
                end else begin
                    want = drive_q.pop_front();
                    check_field("motor_one_leg_a", want.one_a, got.one_a);
                    check_field("motor_one_leg_b", want.one_b, got.one_b);
                    check_field("motor_two_leg_a", want.two_a, got.two_a);
                    check_field("motor_two_leg_b", want.two_b, got.two_b);
                    check_field("drive_status", CMP_W'(want.status), CMP_W'(got.status));
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                tick.temp_ok     = in_ch.temp_ok;
                tick.fault_ok    = in_ch.fault_ok;
                tick.target_one  = in_ch.target_one;
                tick.target_two  = in_ch.target_two;
                tick.elapsed_one = in_ch.elapsed_one;
                tick.elapsed_two = in_ch.elapsed_two;
                drive_q.push_back(predict_drive(tick));
            end
        end
        o_fail_count <= fails;
        o_pending    <= drive_q.size();
    end

endmodule

@@ tb/dual_motor_p_drive_controller_unit_tb.sv @@
// Top of the drive controller testbench: clock, reset, register writes, tick
// stimulus, result back-pressure, watchdog and verdict.
// Depends on dmpd_pkg, both channel interfaces, dmpd_checker and the block.
`timescale 1ns / 1ps

module dual_motor_p_drive_controller_unit_tb;
    import dmpd_pkg::*;

    localparam int N_PHASES        = 8;
    localparam int TICKS_PER_PHASE = 94;
    localparam int WATCHDOG_LIMIT  = 2000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    int                    send_idle;
    int                    recv_stall;
    int                    n_ticks;
    int                    n_results;
    int                    n_writes;
    int                    idle_cycles;
    logic [TIMEOUT_W-1:0]  cur_timeout;

    dmpd_in_if  in_ch ();
    dmpd_out_if res_ch ();

    dual_motor_p_drive_controller_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    dmpd_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .res_ch       (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_in_item make_tick(input logic temp_ok, input logic fault_ok,
                                           input logic signed [TARGET_W-1:0] t1,
                                           input logic signed [TARGET_W-1:0] t2,
                                           input logic [ELAPSED_W-1:0] e1,
                                           input logic [ELAPSED_W-1:0] e2);
        t_in_item it;
        it.temp_ok     = temp_ok;
        it.fault_ok    = fault_ok;
        it.target_one  = t1;
        it.target_two  = t2;
        it.elapsed_one = e1;
        it.elapsed_two = e2;
        return it;
    endfunction

    function automatic logic signed [TARGET_W-1:0] random_target();
        logic [TARGET_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = 16'h7FFF;
            1:       v = 16'h8000;
            2, 3:    v = TARGET_W'($urandom_range(0, 7) - 4);
            4, 5, 6: v = TARGET_W'($urandom_range(0, 9000) - 4500);
            default: v = TARGET_W'($urandom_range(0, 65535));
        endcase
        return v;
    endfunction

    function automatic logic [ELAPSED_W-1:0] random_elapsed();
        case ($urandom_range(0, 9))
            0, 1:    return cur_timeout;
            2:       return cur_timeout + 1'b1;
            3:       return cur_timeout - 1'b1;
            default: return ELAPSED_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic t_in_item random_tick();
        return make_tick($urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0,
                         random_target(), random_target(),
                         random_elapsed(), random_elapsed());
    endfunction

    task automatic send_tick(input t_in_item it);
        while ($urandom_range(0, 99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.temp_ok     <= it.temp_ok;
        in_ch.fault_ok    <= it.fault_ok;
        in_ch.target_one  <= it.target_one;
        in_ch.target_two  <= it.target_two;
        in_ch.elapsed_one <= it.elapsed_one;
        in_ch.elapsed_two <= it.elapsed_two;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        n_ticks++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx r, input logic [CFG_DATA_W-1:0] v);
        cfg_we   <= 1'b1;
        cfg_idx  <= r;
        cfg_data <= v;
        if (r == REG_TIMEOUT)
            cur_timeout = v;
        n_writes++;
        @(negedge i_clk);
    endtask

    task automatic set_registers(input int phase);
        case (phase)
            1: begin
                write_reg(REG_GAIN, 16'hFFFF);
                write_reg(REG_LIMIT, 16'hFFFF);
                write_reg(REG_TIMEOUT, 16'h0000);
                write_reg(REG_IDLE, 16'h0000);
            end
            2: begin
                write_reg(REG_GAIN, 16'h0000);
                write_reg(REG_LIMIT, 16'h0000);
                write_reg(REG_TIMEOUT, 16'hFFFF);
                write_reg(REG_IDLE, 16'h0FFF);
            end
            default: begin
                write_reg(REG_GAIN, CFG_DATA_W'($urandom_range(0, 65535)));
                write_reg(REG_LIMIT, CFG_DATA_W'($urandom_range(0, 65535)));
                write_reg(REG_TIMEOUT, CFG_DATA_W'($urandom_range(0, 65535)));
                write_reg(REG_IDLE, CFG_DATA_W'($urandom_range(0, 65535)));
            end
        endcase
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (pending != 0)
            @(negedge i_clk);
    endtask

    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    initial begin
        idle_cycles = 0;
        n_results   = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (res_ch.valid && res_ch.ready)
                n_results++;
            if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: watchdog, no handshake for %0d cycles", $time, idle_cycles);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        i_rst_n           = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = '0;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.temp_ok     = 1'b1;
        in_ch.fault_ok    = 1'b1;
        in_ch.target_one  = '0;
        in_ch.target_two  = '0;
        in_ch.elapsed_one = '0;
        in_ch.elapsed_two = '0;
        send_idle         = 0;
        recv_stall        = 0;
        n_ticks           = 0;
        n_writes          = 0;
        cur_timeout       = TIMEOUT_RST;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int p = 0; p < N_PHASES; p++) begin
            if (p != 0) begin
                drain();
                repeat (8) @(negedge i_clk);
                set_registers(p);
            end
            case (p % 4)
                0:       begin send_idle = 0;  recv_stall = 0;  end
                1:       begin send_idle = 71; recv_stall = 0;  end
                2:       begin send_idle = 0;  recv_stall = 71; end
                default: begin send_idle = 18; recv_stall = 18; end
            endcase
            if (p == 0) begin
                // saturate both ways, then decay back
                repeat (5) send_tick(make_tick(1'b1, 1'b1, 16'sh7FFF, -16'sh8000, 0, 16'hFFFF));
                repeat (3) send_tick(make_tick(1'b1, 1'b1, 0, 0, 0, 0));
                // timeout hits on exact equality only
                send_tick(make_tick(1'b1, 1'b1, 100, -100, TIMEOUT_RST, TIMEOUT_RST + 1'b1));
                send_tick(make_tick(1'b1, 1'b1, 100, -100, TIMEOUT_RST - 1'b1, TIMEOUT_RST));
                send_tick(make_tick(1'b0, 1'b1, 500, 500, 0, 0));
                send_tick(make_tick(1'b1, 1'b0, 500, 500, 0, 0));
                send_tick(make_tick(1'b0, 1'b0, 500, 500, 0, 0));
                // small levels just either side of zero
                repeat (4) send_tick(make_tick(1'b1, 1'b1, -1, 1, 0, 0));
                repeat (2) send_tick(make_tick(1'b1, 1'b1, 0, 0, 0, 0));
                send_tick(make_tick(1'b1, 1'b1, 2450, -2450, 1, 1));
                send_tick(make_tick(1'b1, 1'b1, 16'sh7FFF, 16'sh7FFF, 16'hFFFF, TIMEOUT_RST));
            end
            repeat (TICKS_PER_PHASE)
                send_tick(random_tick());
            in_ch.valid <= 1'b0;
        end

        drain();
        repeat (10) @(negedge i_clk);
        $display("Sent %0d control ticks, checked %0d results over %0d register phases",
                 n_ticks, n_results, N_PHASES);
        $display("(%0d register writes, fault and timeout cases, mixed stalls)", n_writes);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
